FILE: design/icc_pkg.sv
// Shared types and constants for the 3x3 clamped image convolution core.
// Holds field widths, register codes, the config bundle and the window job.
// No dependencies.
package icc_pkg;

  // Fixed geometry and field widths
  localparam int KERNEL_SIZE  = 3;
  localparam int PIX_W        = 8;
  localparam int LANE_W       = 8;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 11;
  localparam int PMAX_W       = 8;
  localparam int DIVR_W       = 16;
  localparam int KROW_W       = 24;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 24;

  // Row counter saturates here; height is clamped to this many rows
  localparam int ROW_W        = 12;
  localparam int ROW_LIMIT    = 4095;
  localparam int HEIGHT_LIMIT = 1024;

  // Divider: eight quotient bits, remainder wide enough for divisor << 7
  localparam int QUO_W        = 8;
  localparam int DIV_W        = DIVR_W + QUO_W;

  // Job queue between front and back
  localparam int QUEUE_DEPTH  = 4;

  // Register reset values
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET   = 11'd512;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET  = 11'd512;
  localparam logic [PMAX_W-1:0]       PMAX_RESET    = 8'd255;
  localparam logic [DIVR_W-1:0]       DIVR_RESET    = 16'd1;
  localparam logic [KROW_W-1:0]       KTOP_RESET    = 24'h000000;
  localparam logic [KROW_W-1:0]       KMID_RESET    = 24'h010000;
  localparam logic [KROW_W-1:0]       KBOT_RESET    = 24'h000000;

  // Register indexes on the config port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_PIXEL_MAX     = 3'd2,
    REG_DIVISOR       = 3'd3,
    REG_KERNEL_TOP    = 3'd4,
    REG_KERNEL_MIDDLE = 3'd5,
    REG_KERNEL_BOTTOM = 3'd6
  } cfg_reg_e;

  // All configuration registers, kernel rows top to bottom
  typedef struct packed {
    logic [WIDTH_REG_W-1:0]               image_width;
    logic [HEIGHT_REG_W-1:0]              image_height;
    logic [PMAX_W-1:0]                    pixel_max;
    logic [DIVR_W-1:0]                    divisor;
    logic [KERNEL_SIZE-1:0][KROW_W-1:0]   kernel_row;
  } cfg_t;

  // 3x3 neighborhood, indexed [row][column], row 0 on top, column 0 left
  typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] window_t;

  // One filter request from front to back
  typedef struct packed {
    window_t win;
    logic    last;
  } job_t;

endpackage

FILE: design/icc_if.sv
// Stream and config channel interfaces of the convolution core.
// Depends on icc_pkg for field widths.

// Source pixel channel
interface icc_pix_in_if import icc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             flush;

  modport source (output valid, output pixel_in, output flush, input ready);
  modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

// Filtered pixel channel
interface icc_pix_out_if import icc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             last_pixel;

  modport source (output valid, output pixel_out, output last_pixel, input ready);
  modport sink   (input valid, input pixel_out, input last_pixel, output ready);
endinterface

// Register write channel
interface icc_cfg_if import icc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/icc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module icc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/icc_front.sv
// Front end: raster position tracking, two line stores and the 3x3 window.
// Emits one window job per output pixel. Depends on icc_pkg, icc_if, icc_ram.
module icc_front import icc_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic         clk,
  input  logic         rst,
  icc_pix_in_if.sink   pixels,
  input  cfg_t         cfg,
  output job_t         job,
  output logic         job_valid,
  input  logic         job_ready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WE_W  = $clog2(MAX_WIDTH + 1);
  localparam int CNT_W = $clog2(HEIGHT_LIMIT * MAX_WIDTH + 1);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             c0;      // first column: drains the previous row
    logic             emit;
    logic             last;
    logic             wr;      // line stores are updated
    logic             top_en;
    logic             mid_en;
    logic             fwd;     // read collided with the previous write
    logic [PIX_W-1:0] bot;
  } front_item_t;

  // Position state
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [CNT_W-1:0] out_cnt;

  // Second stage, waits for line store data
  logic        b_valid;
  front_item_t b;
  front_item_t b_next;

  // Last line store write, forwarded to a read of the same column
  logic [PIX_W-1:0] fwd_upper;
  logic [PIX_W-1:0] fwd_lower;

  window_t win;
  window_t win_new;
  window_t win_drain;
  window_t win_fresh;

  logic [WIDTH_REG_W-1:0]  w0;
  logic [WE_W-1:0]         w_eff;
  logic [HEIGHT_REG_W-1:0] h0;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [CNT_W:0]          hw;

  logic accept;
  logic b_done;
  logic row_ge1;
  logic row_ge2;
  logic emit_a;
  logic emit_b;
  logic emit;
  logic last;
  logic col_wrap;

  logic [PIX_W-1:0] upper_rd;
  logic [PIX_W-1:0] lower_rd;
  logic [PIX_W-1:0] upper_raw;
  logic [PIX_W-1:0] lower_raw;
  logic [PIX_W-1:0] top_px;
  logic [PIX_W-1:0] mid_px;
  logic             wr_en;

  // Clamp image size to the supported range
  always_comb begin
    w0    = (cfg.image_width == '0) ? WIDTH_REG_W'(1) : cfg.image_width;
    w_eff = (32'(w0) > MAX_WIDTH) ? WE_W'(MAX_WIDTH) : WE_W'(w0);
    h0    = (cfg.image_height == '0) ? HEIGHT_REG_W'(1) : cfg.image_height;
    h_eff = (32'(h0) > HEIGHT_LIMIT) ? HEIGHT_REG_W'(HEIGHT_LIMIT) : h0;
    hw    = (CNT_W+1)'(h_eff) * (CNT_W+1)'(w_eff);
  end

  // Handshake between the two stages
  assign accept        = pixels.valid && pixels.ready;
  assign b_done        = b_valid && (!b.emit || job_ready);
  assign pixels.ready  = !b_valid || b_done;

  // Classify the incoming request from the current position
  always_comb begin
    row_ge1  = (row != '0);
    row_ge2  = (row > ROW_W'(1));
    emit_a   = (col == '0) && row_ge2;
    emit_b   = (col != '0) && row_ge1;
    emit     = emit_a || emit_b;
    last     = emit && (((CNT_W+1)'(out_cnt) + (CNT_W+1)'(1)) >= hw);
    col_wrap = ((WE_W+1)'(col) + (WE_W+1)'(1)) >= (WE_W+1)'(w_eff);

    b_next.col    = col;
    b_next.c0     = (col == '0);
    b_next.emit   = emit;
    b_next.last   = last;
    b_next.wr     = !(emit_a && last);
    b_next.top_en = row_ge2 && ((ROW_W+1)'(row) < (ROW_W+1)'(h_eff) + (ROW_W+1)'(2));
    b_next.mid_en = row_ge1 && ((ROW_W+1)'(row) < (ROW_W+1)'(h_eff) + (ROW_W+1)'(1));
    b_next.fwd    = b_done && b.wr && (b.col == col);
    b_next.bot    = (((ROW_W+1)'(row) < (ROW_W+1)'(h_eff)) && !pixels.flush)
                    ? pixels.pixel_in : '0;
  end

  // Advance position, restart after the final pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      out_cnt <= '0;
    end else if (accept) begin
      if (last) begin
        col     <= '0;
        row     <= '0;
        out_cnt <= '0;
      end else begin
        out_cnt <= out_cnt + CNT_W'(emit);
        if (col_wrap) begin
          col <= '0;
          if (row != ROW_W'(ROW_LIMIT)) begin
            row <= row + ROW_W'(1);
          end
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end

  // Second stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_done) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b <= b_next;
    end
  end

  // Line stores, read at accept, written when the second stage retires
  assign wr_en = b_done && b.wr;

  icc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) upper_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (b.col),
    .wr_data (lower_raw),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (upper_rd)
  );

  icc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) lower_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (b.col),
    .wr_data (b.bot),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (lower_rd)
  );

  // Hold the last write for a back-to-back read of the same column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_upper <= lower_raw;
      fwd_lower <= b.bot;
    end
  end

  // Gate column pixels that fall outside the image
  always_comb begin
    upper_raw = b.fwd ? fwd_upper : upper_rd;
    lower_raw = b.fwd ? fwd_lower : lower_rd;
    top_px    = b.top_en ? upper_raw : '0;
    mid_px    = b.mid_en ? lower_raw : '0;
  end

  // Window candidates: shift in new column, shift in zeros, or restart
  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      win_new[i][0]   = win[i][1];
      win_new[i][1]   = win[i][2];
      win_drain[i][0] = win[i][1];
      win_drain[i][1] = win[i][2];
      win_drain[i][2] = '0;
      win_fresh[i][0] = '0;
      win_fresh[i][1] = '0;
    end
    win_new[0][2]   = top_px;
    win_new[1][2]   = mid_px;
    win_new[2][2]   = b.bot;
    win_fresh[0][2] = top_px;
    win_fresh[1][2] = mid_px;
    win_fresh[2][2] = b.bot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (b_done) begin
      if (b.last) begin
        win <= '0;
      end else if (b.c0) begin
        win <= win_fresh;
      end else begin
        win <= win_new;
      end
    end
  end

  // Filter request toward the queue
  assign job_valid = b_valid && b.emit;
  assign job.win   = b.c0 ? win_drain : win_new;
  assign job.last  = b.last;

endmodule

FILE: design/icc_queue.sv
// Short FIFO of window jobs that decouples front and back.
// Depends on icc_pkg.
module icc_queue import icc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  job_t push_data,
  input  logic push_valid,
  output logic push_ready,
  output job_t pop_data,
  output logic pop_valid,
  input  logic pop_ready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Store request
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/icc_back.sv
// Back end: 3x3 multiply-accumulate, clamp test and an 8-stage restoring
// divider feeding the output register. Depends on icc_pkg and icc_if.
module icc_back import icc_pkg::*; #(
  parameter int COEFF_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  job_t          job,
  input  logic          job_valid,
  output logic          job_ready,
  icc_pix_out_if.source results
);

  localparam int PROD_W  = COEFF_BITS + PIX_W;
  localparam int RS_W    = PROD_W + 2;
  localparam int SUM_W   = PROD_W + 4;
  localparam int LIMIT_W = PMAX_W + DIVR_W;

  typedef struct packed {
    logic             last;
    logic             neg;
    logic             big;
    logic [DIV_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_stage_t;

  logic en;

  logic signed [COEFF_BITS-1:0] coef [KERNEL_SIZE][KERNEL_SIZE];

  // Multiply stage
  logic                     s1_valid;
  logic                     s1_last;
  logic signed [PROD_W-1:0] s1_prod [KERNEL_SIZE][KERNEL_SIZE];
  // Row sum stage
  logic                     s2_valid;
  logic                     s2_last;
  logic signed [RS_W-1:0]   s2_row [KERNEL_SIZE];
  // Total sum stage
  logic                     s3_valid;
  logic                     s3_last;
  logic signed [SUM_W-1:0]  s3_sum;
  // Divider stages, index 0 holds the classified sum
  logic [QUO_W:0]           dv_valid;
  div_stage_t               dv      [QUO_W+1];
  div_stage_t               dv_next [QUO_W+1];
  // Output register
  logic                     out_valid;
  logic [PIX_W-1:0]         out_pixel;
  logic                     out_last;

  logic [PMAX_W-1:0]  pm_eff;
  logic [PMAX_W-1:0]  top_val;
  logic [DIVR_W-1:0]  d_eff;
  logic [LIMIT_W-1:0] limit;

  // Whole pipeline moves unless the output holds an untaken result
  assign en        = !out_valid || results.ready;
  assign job_ready = en;

  assign results.valid      = out_valid;
  assign results.pixel_out  = out_pixel;
  assign results.last_pixel = out_last;

  // Effective config values
  always_comb begin
    pm_eff  = (cfg.pixel_max == '0) ? PMAX_W'(1) : cfg.pixel_max;
    top_val = pm_eff - PMAX_W'(1);
    d_eff   = (cfg.divisor == '0) ? DIVR_W'(1) : cfg.divisor;
  end

  // Quotient reaches pixel_max exactly when the sum reaches this bound
  always_ff @(posedge clk) begin
    limit <= LIMIT_W'(pm_eff) * LIMIT_W'(d_eff);
  end

  // Pick coefficients out of the byte lanes
  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        coef[i][j] = signed'(cfg.kernel_row[i][LANE_W*j +: COEFF_BITS]);
      end
    end
  end

  // Divider steps: one quotient bit per stage, most significant first
  always_comb begin
    dv_next[0].last = s3_last;
    dv_next[0].neg  = s3_sum[SUM_W-1] || (s3_sum == '0);
    dv_next[0].rem  = DIV_W'(s3_sum[SUM_W-2:0]);
    dv_next[0].big  = !dv_next[0].neg && (DIV_W'(s3_sum[SUM_W-2:0]) >= DIV_W'(limit));
    dv_next[0].quo  = '0;
    for (int k = 0; k < QUO_W; k++) begin
      dv_next[k+1] = dv[k];
      if (dv[k].rem >= (DIV_W'(d_eff) << (QUO_W - 1 - k))) begin
        dv_next[k+1].rem             = dv[k].rem - (DIV_W'(d_eff) << (QUO_W - 1 - k));
        dv_next[k+1].quo[QUO_W-1-k]  = 1'b1;
      end
    end
  end

  // Valid bits along the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      dv_valid  <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= job_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      dv_valid  <= {dv_valid[QUO_W-1:0], s3_valid};
      out_valid <= dv_valid[QUO_W];
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // multiply each pixel by its coefficient
      s1_last <= job.last;
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        for (int j = 0; j < KERNEL_SIZE; j++) begin
          s1_prod[i][j] <= PROD_W'(coef[i][j]) * PROD_W'(signed'({1'b0, job.win[i][j]}));
        end
      end
      // sum along rows
      s2_last <= s1_last;
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        s2_row[i] <= RS_W'(s1_prod[i][0]) + RS_W'(s1_prod[i][1]) + RS_W'(s1_prod[i][2]);
      end
      // sum rows
      s3_last <= s2_last;
      s3_sum  <= SUM_W'(s2_row[0]) + SUM_W'(s2_row[1]) + SUM_W'(s2_row[2]);
      // divide
      for (int k = 0; k <= QUO_W; k++) begin
        dv[k] <= dv_next[k];
      end
      // clamp into the output register
      out_last <= dv[QUO_W].last;
      if (dv[QUO_W].neg) begin
        out_pixel <= '0;
      end else if (dv[QUO_W].big) begin
        out_pixel <= top_val;
      end else begin
        out_pixel <= dv[QUO_W].quo;
      end
    end
  end

endmodule

FILE: design/image_convolution_3x3_clamped_core.sv
// 3x3 zero-padded convolution core: one pixel accepted per clock sustained while
// results are taken. The result of a request passes the line store read stage,
// the job queue, three multiply-add stages, one clamp stage, eight divider stages
// and the output register. Results lag pixels by one row plus one pixel.
// Synchronous reset restores register defaults and clears the position counters,
// window, queue and pipeline; line stores are not cleared.
module image_convolution_3x3_clamped_core import icc_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int COEFF_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  icc_pix_in_if.sink    pixels,
  icc_pix_out_if.source results,
  icc_cfg_if.sink       cfg
);

  cfg_t cfg_regs;

  job_t front_job;
  logic front_job_valid;
  logic front_job_ready;
  job_t back_job;
  logic back_job_valid;
  logic back_job_ready;

  // Register writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.image_width   <= WIDTH_RESET;
      cfg_regs.image_height  <= HEIGHT_RESET;
      cfg_regs.pixel_max     <= PMAX_RESET;
      cfg_regs.divisor       <= DIVR_RESET;
      cfg_regs.kernel_row[0] <= KTOP_RESET;
      cfg_regs.kernel_row[1] <= KMID_RESET;
      cfg_regs.kernel_row[2] <= KBOT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_IMAGE_WIDTH:   cfg_regs.image_width   <= cfg.data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_regs.image_height  <= cfg.data[HEIGHT_REG_W-1:0];
        REG_PIXEL_MAX:     cfg_regs.pixel_max     <= cfg.data[PMAX_W-1:0];
        REG_DIVISOR:       cfg_regs.divisor       <= cfg.data[DIVR_W-1:0];
        REG_KERNEL_TOP:    cfg_regs.kernel_row[0] <= cfg.data[KROW_W-1:0];
        REG_KERNEL_MIDDLE: cfg_regs.kernel_row[1] <= cfg.data[KROW_W-1:0];
        REG_KERNEL_BOTTOM: cfg_regs.kernel_row[2] <= cfg.data[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  icc_front #(.MAX_WIDTH(MAX_WIDTH)) front (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .cfg       (cfg_regs),
    .job       (front_job),
    .job_valid (front_job_valid),
    .job_ready (front_job_ready)
  );

  icc_queue #(.DEPTH(QUEUE_DEPTH)) queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_job),
    .push_valid (front_job_valid),
    .push_ready (front_job_ready),
    .pop_data   (back_job),
    .pop_valid  (back_job_valid),
    .pop_ready  (back_job_ready)
  );

  icc_back #(.COEFF_BITS(COEFF_BITS)) back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .job       (back_job),
    .job_valid (back_job_valid),
    .job_ready (back_job_ready),
    .results   (results)
  );

endmodule

FILE: dv/icc_conv_checker.sv
// Checker for the 3x3 clamped convolution core: watches the pixel, result and
// register channels, predicts each filtered pixel and compares results in order.
// Depends on icc_pkg and the channel interfaces of icc_if.sv.
module icc_conv_checker import icc_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic   clk,
  input  logic   rst,
  icc_pix_in_if  pixels,
  icc_pix_out_if results,
  icc_cfg_if     cfg,
  output int     mismatches,
  output int     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } filtered_t;

  // Predicted results, oldest first
  filtered_t expected_pixels[$];

  // Shadow registers; kernel row 0 is the top row
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [PMAX_W-1:0]       pmax_reg;
  logic [DIVR_W-1:0]       divisor_reg;
  logic [KROW_W-1:0]       kernel_row [KERNEL_SIZE];

  // Shadow line stores, neighborhood and raster position
  logic [PIX_W-1:0] store_upper [MAX_WIDTH];
  logic [PIX_W-1:0] store_lower [MAX_WIDTH];
  window_t          nbhd;
  int unsigned      in_col, in_row, out_count;

  function automatic void restore_defaults();
    width_reg     = WIDTH_RESET;
    height_reg    = HEIGHT_RESET;
    pmax_reg      = PMAX_RESET;
    divisor_reg   = DIVR_RESET;
    kernel_row[0] = KTOP_RESET;
    kernel_row[1] = KMID_RESET;
    kernel_row[2] = KBOT_RESET;
    nbhd          = '0;
    in_col        = 0;
    in_row        = 0;
    out_count     = 0;
    expected_pixels.delete();
  endfunction

  function automatic void write_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_IMAGE_WIDTH:   width_reg     = value[WIDTH_REG_W-1:0];
      REG_IMAGE_HEIGHT:  height_reg    = value[HEIGHT_REG_W-1:0];
      REG_PIXEL_MAX:     pmax_reg      = value[PMAX_W-1:0];
      REG_DIVISOR:       divisor_reg   = value[DIVR_W-1:0];
      REG_KERNEL_TOP:    kernel_row[0] = value[KROW_W-1:0];
      REG_KERNEL_MIDDLE: kernel_row[1] = value[KROW_W-1:0];
      REG_KERNEL_BOTTOM: kernel_row[2] = value[KROW_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the neighborhood by one column, new column on the right
  function automatic void shift_window(input logic [PIX_W-1:0] t, m, b);
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2] = t;
    nbhd[1][2] = m;
    nbhd[2][2] = b;
  endfunction

  // Weighted sum, divide toward zero, clamp to 0 .. pixel_max-1
  function automatic logic [PIX_W-1:0] weighted_pixel();
    int sum, quo, d, top;
    logic signed [LANE_W-1:0] coef;
    sum = 0;
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      for (int j = 0; j < KERNEL_SIZE; j++) begin
        coef = kernel_row[i][LANE_W*j +: LANE_W];
        sum += int'(coef) * int'(nbhd[i][j]);
      end
    end
    d   = (divisor_reg == 0) ? 1 : int'(divisor_reg);
    top = ((pmax_reg == 0) ? 1 : int'(pmax_reg)) - 1;
    quo = sum / d;
    if (quo < 0) quo = 0;
    if (quo > top) quo = top;
    return quo[PIX_W-1:0];
  endfunction

  // Queue one filtered pixel; on the final pixel clear position and window
  function automatic bit emit_pixel(input int unsigned total);
    filtered_t res;
    res.pixel = weighted_pixel();
    res.last  = (out_count + 1 >= total);
    expected_pixels.push_back(res);
    if (res.last) begin
      nbhd      = '0;
      in_col    = 0;
      in_row    = 0;
      out_count = 0;
    end else begin
      out_count++;
    end
    return res.last;
  endfunction

  // Predict the effect of one accepted pixel request
  function automatic void convolve_step(input logic [PIX_W-1:0] pix, input logic fl);
    int unsigned w, h, c, r, total;
    logic [PIX_W-1:0] t, m, b;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    total = w * h;
    c = in_col;
    r = in_row;

    // Row start: finish the last column of the row two above
    if (c == 0 && r >= 2) begin
      shift_window('0, '0, '0);
      if (emit_pixel(total)) return;
    end
    if (c == 0) nbhd = '0;

    // Read the column, pad outside the image, flush pixels count as zero
    t = (r >= 2 && r - 2 < h) ? store_upper[c] : '0;
    m = (r >= 1 && r - 1 < h) ? store_lower[c] : '0;
    b = (r < h && !fl) ? pix : '0;
    store_upper[c] = store_lower[c];
    store_lower[c] = b;
    shift_window(t, m, b);

    if (c >= 1 && r >= 1) begin
      if (emit_pixel(total)) return;
    end

    if (c + 1 >= w) begin
      in_col = 0;
      if (r < ROW_LIMIT) in_row = r + 1;
    end else begin
      in_col = c + 1;
    end
  endfunction

  // Compare results before predicting, so a new request never meets its own result
  always @(posedge clk) begin : track
    filtered_t want;
    if (rst) begin
      restore_defaults();
      mismatches = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual pixel_out %0d last_pixel %0b",
                   $time, results.pixel_out, results.last_pixel);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (results.pixel_out !== want.pixel) begin
            $display("%0t: pixel_out mismatch: expected %0d actual %0d",
                     $time, want.pixel, results.pixel_out);
            mismatches++;
          end
          if (results.last_pixel !== want.last) begin
            $display("%0t: last_pixel mismatch: expected %0b actual %0b",
                     $time, want.last, results.last_pixel);
            mismatches++;
          end
        end
      end
      if (cfg.valid && cfg.ready) write_register(cfg.index, cfg.data);
      if (pixels.valid && pixels.ready) convolve_step(pixels.pixel_in, pixels.flush);
    end
    outstanding <= expected_pixels.size();
  end

endmodule

FILE: dv/tb.sv
// Top of the convolution core testbench: clock, reset, request stimulus and
// register setup. Depends on icc_pkg, icc_if.sv, icc_conv_checker and the core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import icc_pkg::*;

  localparam int MAX_WIDTH     = 1024;
  localparam int RANDOM_ITEMS  = 630;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT   = 4000;
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

  logic clk;
  logic rst;
  int   src_idle_pct   = 10;
  int   sink_stall_pct = 86;
  int   random_items   = 0;
  int   quiet_cycles   = 0;
  int   img_w, img_h;
  int   mismatches, outstanding;

  icc_pix_in_if  pix_if ();
  icc_pix_out_if res_if ();
  icc_cfg_if     cfg_if ();

  image_convolution_3x3_clamped_core #(.MAX_WIDTH(MAX_WIDTH)) u_top (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_if),
    .results (res_if),
    .cfg     (cfg_if)
  );

  icc_conv_checker #(.MAX_WIDTH(MAX_WIDTH)) u_check (
    .clk         (clk),
    .rst         (rst),
    .pixels      (pix_if),
    .results     (res_if),
    .cfg         (cfg_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Drop the run if no channel moves for too long
  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold valid on one register write until taken; caller lowers valid
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] wd, hd, pm, dv, kt, km, kb);
    int wv, hv;
    write_reg(REG_IMAGE_WIDTH, wd);
    write_reg(REG_IMAGE_HEIGHT, hd);
    write_reg(REG_PIXEL_MAX, pm);
    write_reg(REG_DIVISOR, dv);
    write_reg(REG_KERNEL_TOP, kt);
    write_reg(REG_KERNEL_MIDDLE, km);
    write_reg(REG_KERNEL_BOTTOM, kb);
    cfg_if.valid <= 1'b0;
    // Image geometry as the core counts it
    wv = int'(wd[WIDTH_REG_W-1:0]);
    hv = int'(hd[HEIGHT_REG_W-1:0]);
    img_w = (wv == 0) ? 1 : ((wv > MAX_WIDTH) ? MAX_WIDTH : wv);
    img_h = (hv == 0) ? 1 : ((hv > HEIGHT_LIMIT) ? HEIGHT_LIMIT : hv);
  endtask

  // Idle at random, then hold one pixel request until taken
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fl);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid    <= 1'b1;
    pix_if.pixel_in <= pix;
    pix_if.flush    <= fl;
    do @(posedge clk); while (!pix_if.ready);
  endtask

  // Stop sending until every predicted result has come back
  task automatic hold_until_drained(input int settle);
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // One image of random pixels plus its drain requests
  task automatic send_image(input bit pause_midway);
    int body, total;
    logic [PIX_W-1:0] pix;
    logic fl;
    body  = img_w * img_h;
    total = body + img_w + 1;
    for (int k = 0; k < total; k++) begin
      if (random_items < RANDOM_ITEMS / 3) begin
        src_idle_pct   = 10;
        sink_stall_pct = 86;
      end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct   = 86;
        sink_stall_pct = 10;
      end else begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      pix = 8'($urandom);
      if (k < body) fl = ($urandom_range(99) < 3);
      else fl = ($urandom_range(99) < 70);
      if (pause_midway && k == body / 2) hold_until_drained(0);
      send_pixel(pix, fl);
      random_items++;
    end
  endtask

  initial begin : stimulus
    int w, h, pm, dv;
    bit gentle, pause, paused_once;
    logic [KROW_W-1:0] krow [KERNEL_SIZE];

    rst             <= 1'b1;
    pix_if.valid    <= 1'b0;
    pix_if.pixel_in <= '0;
    pix_if.flush    <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_IMAGE_WIDTH;
    cfg_if.data     <= '0;
    paused_once = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // 3x3 image of extreme pixels, mixed-sign kernel, flush inside the image
    // and a real pixel during the drain
    configure(24'd3, 24'd3, 24'd255, 24'd3, 24'h80FF01, 24'h7F0203, 24'hFE7F80);
    for (int k = 0; k < 13; k++) begin
      if (k < 9) send_pixel((k % 2) ? 8'h00 : 8'hFF, k == 4);
      else send_pixel((k == 11) ? 8'hA5 : 8'h00, k != 11);
    end
    hold_until_drained(SETTLE_CYCLES);

    // Zero width, height, pixel_max and divisor; unmapped register index
    write_reg(REG_UNMAPPED, 24'hFFFFFF);
    configure(24'h000000, 24'h000000, 24'h000000, 24'h000000,
              24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h5A, 1'b0);
    hold_until_drained(SETTLE_CYCLES);

    // Random small images, one to three per setting
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(9) == 0) w = $urandom_range(13, 40);
      else w = $urandom_range(0, 12);
      h  = $urandom_range(0, 8);
      pm = ($urandom_range(3) == 0) ? 255 : $urandom_range(0, 255);
      case ($urandom_range(9))
        0:       dv = $urandom_range(0, 65535);
        1:       dv = 0;
        default: dv = $urandom_range(1, 48);
      endcase
      gentle = $urandom_range(1);
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        if (gentle) krow[i] = {8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                               8'($urandom_range(0, 6))};
        else krow[i] = 24'($urandom);
      end
      configure({13'($urandom), 11'(w)}, {13'($urandom), 11'(h)},
                {16'($urandom), 8'(pm)}, {8'($urandom), 16'(dv)},
                krow[0], krow[1], krow[2]);
      repeat ($urandom_range(1, 3)) begin
        pause = !paused_once && (img_w * img_h >= 8);
        if (pause) paused_once = 1'b1;
        send_image(pause);
      end
      hold_until_drained(SETTLE_CYCLES);
    end

    // Short image, largest divisor and coefficients
    configure(24'h000008, 24'h000002, 24'hFFFFFF, 24'hFFFFFF,
              24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    send_image(1'b0);
    hold_until_drained(SETTLE_CYCLES);

    // Tallest image, one pixel wide, Laplacian kernel
    configure(24'h000001, 24'h0007FF, 24'h000080, 24'h000001,
              24'h00FF00, 24'hFF04FF, 24'h00FF00);
    send_image(1'b0);
    hold_until_drained(SETTLE_CYCLES);

    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
design/icc_pkg.sv
design/icc_if.sv
design/icc_ram.sv
design/icc_front.sv
design/icc_queue.sv
design/icc_back.sv
design/image_convolution_3x3_clamped_core.sv
dv/icc_conv_checker.sv
dv/tb.sv
